### hdl/nssm_pkg.sv
`timescale 1ns / 1ps
// Package for the NFA symbol stream matcher: transaction payload types, command
// codes, register indexes and the control bundle shared by the matcher cells.
// No dependencies.
package nssm_pkg;

   // Widths fixed by the transaction format.
   localparam int CMD_W      = 2;
   localparam int SYMBOL_W   = 8;
   localparam int STATE_ID_W = 5;
   localparam int MASK_W     = 32;
   localparam int CSR_IDX_W  = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FEED   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PRESENT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEPTING = 2'd2;

   // Request transaction.
   typedef struct packed {
      logic [CMD_W-1:0]      command;
      logic [SYMBOL_W-1:0]   symbol;
      logic [STATE_ID_W-1:0] source_state;
      logic [STATE_ID_W-1:0] target_state;
   } req_payload_type;

   // Response transaction.
   typedef struct packed {
      logic [MASK_W-1:0] active_set;
      logic              accepted;
      logic              status;
   } rsp_payload_type;

   // Memory control broadcast to every cell; cells use the low bits they need.
   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [SYMBOL_W-1:0] addr;
      logic [MASK_W-1:0]   wr_data;
   } cell_ctrl_type;

endpackage

### hdl/nssm_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/nssm_cell.sv
`timescale 1ns / 1ps
// One matcher cell: owns the transition rows of one source state (one row per
// symbol) and one stage of the OR chain. Depends on nssm_pkg and nssm_ram.
module nssm_cell
   import nssm_pkg::*;
#(
   parameter int ROW_W       = 32,
   parameter int NUM_SYMBOLS = 256
) (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic             wr_sel,
   input  logic             active,
   input  logic [ROW_W-1:0] acc_in,
   output logic [ROW_W-1:0] acc_out,
   output logic [ROW_W-1:0] row
);

   localparam int SYM_AW = $clog2(NUM_SYMBOLS);

   logic [ROW_W-1:0] acc_ff;
   logic [ROW_W-1:0] acc_in_w;

   // Transition rows of this state, addressed by symbol.
   nssm_ram #(
      .WIDTH(ROW_W),
      .DEPTH(NUM_SYMBOLS)
   ) u_rows (
      .clock  (clock),
      .wr_en  (ctrl.wr_en && wr_sel),
      .wr_addr(ctrl.addr[SYM_AW-1:0]),
      .wr_data(ctrl.wr_data[ROW_W-1:0]),
      .rd_en  (ctrl.rd_en),
      .rd_addr(ctrl.addr[SYM_AW-1:0]),
      .rd_data(row)
   );

   // Chain stage: add this state's row when it is active and pass it on.
   assign acc_in_w = acc_in | (active ? row : '0);

   always_ff @(posedge clock) begin
      acc_ff <= acc_in_w;
   end

   assign acc_out = acc_ff;

endmodule

### hdl/nfa_symbol_stream_matcher.sv
`timescale 1ns / 1ps
// NFA symbol stream matcher, top level. Depends on nssm_pkg and nssm_cell.
// Path from acceptance to the response register: a start word goes straight to the done
// state, add or remove passes the modify state, feed sweeps the OR chain one cell per cycle.
// Throughput: one transaction at a time, the next accepted the cycle after a response loads.
// Reset (synchronous) clears the control and configuration registers and the active set, then
// sweeps every transition row to zero, with req_stall high throughout.
module nfa_symbol_stream_matcher
   import nssm_pkg::*;
#(
   parameter int NUM_STATES  = 32,
   parameter int NUM_SYMBOLS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   // Response channel.
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   // Configuration write port.
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MASK_W-1:0]    csr_wr_data
);

   // States above 31 can never be named, so at most 32 cells are built.
   localparam int ROW_W      = (NUM_STATES < MASK_W) ? NUM_STATES : MASK_W;
   localparam int NUM_CELLS  = ROW_W;
   localparam int CELL_IDX_W = $clog2(NUM_CELLS);
   localparam int SYM_AW     = $clog2(NUM_SYMBOLS);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SWEEP  = 3'd2;
   localparam logic [2:0] S_MODIFY = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [SYM_AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [CELL_IDX_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [ROW_W-1:0]      active_ff, active_in;
   logic                  status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   req_payload_type       item_ff;
   rsp_payload_type       rsp_payload_ff;
   logic [MASK_W-1:0]     present_ff, initial_ff, accepting_ff;

   logic                  req_accept;
   logic                  out_free;
   logic                  rsp_load;
   cell_ctrl_type         cell_ctrl;
   logic [NUM_CELLS-1:0]  cell_wr_sel;
   logic [ROW_W-1:0]      cell_row    [NUM_CELLS];
   logic [ROW_W-1:0]      cell_acc    [NUM_CELLS];
   logic [ROW_W-1:0]      cell_acc_in [NUM_CELLS];

   logic                  sym_ok, src_ok, dst_ok;
   logic [CELL_IDX_W-1:0] src_idx, dst_idx;
   logic [ROW_W-1:0]      src_row, dst_bit, new_row;
   logic                  has_bit;
   logic                  mod_status;
   logic [ROW_W-1:0]      active_new;

   // Handshake.
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == S_DONE) && out_free;

   // Checks on the held transaction.
   assign sym_ok  = (9'(item_ff.symbol) < 9'(NUM_SYMBOLS));
   assign src_ok  = (6'(item_ff.source_state) < 6'(NUM_CELLS))
                    && present_ff[item_ff.source_state];
   assign dst_ok  = (6'(item_ff.target_state) < 6'(NUM_CELLS))
                    && present_ff[item_ff.target_state];
   assign src_idx = item_ff.source_state[CELL_IDX_W-1:0];
   assign dst_idx = item_ff.target_state[CELL_IDX_W-1:0];

   // Transition change: look up the bit in the source row and flip it when allowed.
   assign src_row = cell_row[src_idx];
   assign dst_bit = ROW_W'(1) << dst_idx;
   assign has_bit = |(src_row & dst_bit);
   assign new_row = src_row ^ dst_bit;
   assign mod_status = !(sym_ok && src_ok && dst_ok)
                       || ((item_ff.command == CMD_ADD) ? has_bit : !has_bit);

   // Memory control shared by all cells.
   always_comb begin
      cell_ctrl.rd_en   = req_accept && (req_payload.command != CMD_START);
      cell_ctrl.wr_en   = (state_ff == S_CLEAR)
                          || ((state_ff == S_MODIFY) && !mod_status);
      cell_ctrl.wr_data = (state_ff == S_CLEAR) ? '0 : MASK_W'(new_row);
      if (state_ff == S_CLEAR) begin
         cell_ctrl.addr = SYMBOL_W'(clr_cnt_ff);
      end else if (state_ff == S_IDLE) begin
         cell_ctrl.addr = req_payload.symbol;
      end else begin
         cell_ctrl.addr = item_ff.symbol;
      end
   end

   // Row of cells, the OR chain running from cell 0 to the last cell.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_acc_in[i] = '0;
      end else begin : g_link
         assign cell_acc_in[i] = cell_acc[i-1];
      end

      assign cell_wr_sel[i] = (state_ff == S_CLEAR) || (src_idx == CELL_IDX_W'(i));

      nssm_cell #(
         .ROW_W      (ROW_W),
         .NUM_SYMBOLS(NUM_SYMBOLS)
      ) u_cell (
         .clock  (clock),
         .ctrl   (cell_ctrl),
         .wr_sel (cell_wr_sel[i]),
         .active (active_ff[i]),
         .acc_in (cell_acc_in[i]),
         .acc_out(cell_acc[i]),
         .row    (cell_row[i])
      );
   end

   // Active set after the held transaction.
   always_comb begin
      case (item_ff.command)
         CMD_START: active_new = initial_ff[ROW_W-1:0];
         CMD_FEED:  active_new = sym_ok ? cell_acc[NUM_CELLS-1] : '0;
         default:   active_new = active_ff;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      sweep_cnt_in = sweep_cnt_ff;
      status_in    = status_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SYM_AW'(NUM_SYMBOLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               status_in    = 1'b0;
               sweep_cnt_in = '0;
               case (req_payload.command)
                  CMD_START: state_in = S_DONE;
                  CMD_FEED:  state_in = S_SWEEP;
                  default:   state_in = S_MODIFY;
               endcase
            end
         end
         S_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == CELL_IDX_W'(NUM_CELLS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_MODIFY: begin
            status_in = mod_status;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               active_in    = active_new;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         sweep_cnt_ff <= '0;
         status_ff    <= 1'b0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         present_ff   <= '0;
         initial_ff   <= '0;
         accepting_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         sweep_cnt_ff <= sweep_cnt_in;
         status_ff    <= status_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_PRESENT:   present_ff   <= csr_wr_data;
               REG_INITIAL:   initial_ff   <= csr_wr_data;
               REG_ACCEPTING: accepting_ff <= csr_wr_data;
               default:       ;
            endcase
         end
      end
   end

   // Held request and response payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_payload_ff.active_set <= MASK_W'(active_new);
         rsp_payload_ff.accepted   <= |(MASK_W'(active_new) & accepting_ff);
         rsp_payload_ff.status     <= status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   // The store is never written while the OR chain is being swept.
   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> !cell_ctrl.wr_en)
      else $error("transition store written during a sweep");

   // A rejected change never touches the store.
   a_reject_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MODIFY) && mod_status) |-> !cell_ctrl.wr_en)
      else $error("rejected change wrote the transition store");

   // A transition change leaves the active set alone.
   a_modify_keeps_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY) |=> $stable(active_ff))
      else $error("transition change altered the active set");

   // A finished transaction shows up on the response channel in the next cycle.
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid && (state_ff == S_IDLE)))
      else $error("finished transaction did not reach the response register");
`endif

endmodule
